// File: rtl/sfr_pkg.sv
// Shared types and constants for the serial frame receiver.
package sfr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned OUT_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_MARKER = 8'd1;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h1B;
    localparam logic [BYTE_W-1:0] TOKEN_MARKER_RST = 8'h0E;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_FRAME_OK  = 2'd1,
        KIND_FRAME_BAD = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              last_payload;
        logic [BYTE_W-1:0] frame_seq;
        logic [LEN_W-1:0]  frame_length;
    } t_result;

endpackage

// File: rtl/sfr_cfg.sv
// Configuration registers holding the start and token marker values.
module sfr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [sfr_pkg::BYTE_W-1:0]    i_wr_data,
    output logic [sfr_pkg::BYTE_W-1:0]    o_start_marker,
    output logic [sfr_pkg::BYTE_W-1:0]    o_token_marker
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] r_start_marker;
    logic [BYTE_W-1:0] r_token_marker;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_token_marker <= TOKEN_MARKER_RST;
        end else if (i_wr_en) begin
            if (i_wr_index == CFG_START_MARKER) begin
                r_start_marker <= i_wr_data;
            end
            if (i_wr_index == CFG_TOKEN_MARKER) begin
                r_token_marker <= i_wr_data;
            end
        end
    end

    assign o_start_marker = r_start_marker;
    assign o_token_marker = r_token_marker;

endmodule

// File: rtl/sfr_parser.sv
// Frame parser state machine that consumes one byte per transfer.
module sfr_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_byte_valid,
    input  logic [sfr_pkg::BYTE_W-1:0] i_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] i_start_marker,
    input  logic [sfr_pkg::BYTE_W-1:0] i_token_marker,
    output logic                       o_res_valid,
    output sfr_pkg::t_result           o_res
);
    import sfr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SEQ   = 3'd1,
        PH_LENH  = 3'd2,
        PH_LENL  = 3'd3,
        PH_TOKEN = 3'd4,
        PH_DATA  = 3'd5,
        PH_CHECK = 3'd6
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic [BYTE_W-1:0] r_seq, n_seq;
    logic [LEN_W-1:0]  r_length, n_length;
    logic [LEN_W-1:0]  r_seen, n_seen;
    logic [BYTE_W-1:0] xor_in;
    logic [LEN_W-1:0]  seen_inc;
    logic              is_last;

    assign xor_in   = r_xor ^ i_byte;
    assign seen_inc = r_seen + LEN_W'(1);
    assign is_last  = (seen_inc == r_length);

    always_comb begin
        n_phase     = r_phase;
        n_xor       = r_xor;
        n_seq       = r_seq;
        n_length    = r_length;
        n_seen      = r_seen;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_PAYLOAD, payload_byte: '0, last_payload: 1'b0,
                        frame_seq: r_seq, frame_length: r_length};
        if (i_byte_valid) begin
            case (r_phase)
                PH_SEQ: begin
                    n_xor   = xor_in;
                    n_seq   = i_byte;
                    n_phase = PH_LENH;
                end
                PH_LENH: begin
                    n_xor    = xor_in;
                    n_length = {i_byte, {BYTE_W{1'b0}}};
                    n_phase  = PH_LENL;
                end
                PH_LENL: begin
                    n_xor    = xor_in;
                    n_length = {r_length[LEN_W-1:BYTE_W], i_byte};
                    n_phase  = PH_TOKEN;
                end
                PH_TOKEN: begin
                    if (i_byte != i_token_marker) begin
                        n_xor   = '0;
                        n_phase = PH_HUNT;
                    end else begin
                        n_xor   = xor_in;
                        n_seen  = '0;
                        n_phase = (r_length == '0) ? PH_CHECK : PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_xor                = xor_in;
                    n_seen               = seen_inc;
                    o_res_valid          = 1'b1;
                    o_res.payload_byte   = i_byte;
                    o_res.last_payload   = is_last;
                    if (is_last) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    o_res_valid = 1'b1;
                    o_res.kind  = (xor_in == '0) ? KIND_FRAME_OK : KIND_FRAME_BAD;
                    n_xor       = '0;
                    n_seen      = '0;
                    n_phase     = PH_HUNT;
                end
                default: begin
                    if (i_byte == i_start_marker) begin
                        n_xor   = i_byte;
                        n_phase = PH_SEQ;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_xor    <= '0;
            r_seq    <= '0;
            r_length <= '0;
            r_seen   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_xor    <= n_xor;
            r_seq    <= n_seq;
            r_length <= n_length;
            r_seen   <= n_seen;
        end
    end

endmodule

// File: rtl/sfr_out_reg.sv
// Output register that holds one result until the downstream side takes it.
module sfr_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  sfr_pkg::t_result i_res,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output sfr_pkg::t_result o_res
);
    import sfr_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_room = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: rtl/serial_frame_receiver_xor_check.sv
// Top level of the serial frame receiver with XOR checksum.
// The receiver takes one byte per clock cycle while its output register has
// room; each result is registered and shown on the output in the cycle after
// its input transfer. Each byte updates the frame state registers and any
// result lands in one output register, so a new byte is taken whenever that
// register is empty or being drained in the same cycle. Payload bytes come
// out with tuser = 0 and tlast on the last payload byte; the checksum byte
// gives tuser = 1 (good) or 2 (bad). Marker registers (index 0 start marker,
// index 1 token marker) should be written only while no frame is in flight.
module serial_frame_receiver_xor_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] payload_byte, [15:8] frame_seq,
                                          // [31:16] frame_length
    output logic        o_m_axis_tlast,   // last_payload
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import sfr_pkg::*;

    logic              room;
    logic              byte_valid;
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] token_marker;
    logic              res_valid;
    t_result           res;
    t_result           out_res;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = room;
    assign byte_valid      = i_s_axis_tvalid && room;

    sfr_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_en        (i_cfg_valid),
        .i_wr_index     (i_cfg_index),
        .i_wr_data      (i_cfg_data),
        .o_start_marker (start_marker),
        .o_token_marker (token_marker)
    );

    sfr_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte_valid   (byte_valid),
        .i_byte         (i_s_axis_tdata),
        .i_start_marker (start_marker),
        .i_token_marker (token_marker),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    sfr_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_room      (room),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_res       (out_res)
    );

    assign o_m_axis_tdata = {out_res.frame_length, out_res.frame_seq, out_res.payload_byte};
    assign o_m_axis_tlast = out_res.last_payload;
    assign o_m_axis_tuser = out_res.kind;

endmodule
